### src/tked_pkg.sv
package tked_pkg;

  localparam int READ_BYTES_DEF = 16;
  localparam int HELD_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ESC = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FKEY = 3'd7;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_ESC = 8'h1B;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] esc;
    logic [7:0] enter;
    logic [7:0] ctrl;
    logic [7:0] fkey;
  } cfg_t;

  // key request from the decoder to the held-key table
  typedef struct packed {
    logic       valid;
    logic       press;
    logic [7:0] key;
  } key_req_t;

  // plain byte translation
  function automatic logic [7:0] plain_key(input logic [7:0] b, input logic [7:0] ctrl);
    logic [7:0] r;
    r = b;
    if (b >= 8'h01 && b <= 8'h1A && b != BYTE_LF && b != BYTE_CR) r = ctrl;
    else if (b >= 8'h41 && b <= 8'h5A) r = b + 8'd32;
    return r;
  endfunction

endpackage

### src/tked_if.sv
interface tked_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] in_byte;
  logic       last_of_read;
  modport source(output valid, func, in_byte, last_of_read, input ready);
  modport sink(input valid, func, in_byte, last_of_read, output ready);
endinterface

interface tked_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [7:0] key_code;
  logic       key_pressed;
  modport source(output valid, event_valid, key_code, key_pressed, input ready);
  modport sink(input valid, event_valid, key_code, key_pressed, output ready);
endinterface

interface tked_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/terminal_key_event_decoder_top.sv
// Terminal key event decoder.
// Channels: in_ch (func, in_byte, last_of_read), out_ch (event_valid,
// key_code, key_pressed) and cfg_ch (index, data), all valid/ready.
// A byte item (func 0) gives no result; the byte is stored in the read
// buffer. A byte flagged last_of_read starts decode: a sequencer walks the
// stored bytes through one buffer read port, and each key scans the
// held-key table one slot per cycle. The block is not ready until decode
// finishes. A pop item (func 1) returns one result, held in an output
// register until taken; no new item is accepted while it waits, so a
// stalled receiver stalls the input.
// Reset is synchronous: clears the read count, held table, ring pointers
// and restores register reset values.
module terminal_key_event_decoder_top #(
  parameter int READ_BYTES = tked_pkg::READ_BYTES_DEF,
  parameter int HELD_SLOTS = tked_pkg::HELD_SLOTS_DEF,
  parameter int QUEUE_DEPTH = tked_pkg::QUEUE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  tked_in_if.sink    in_ch,
  tked_out_if.source out_ch,
  tked_cfg_if.sink   cfg_ch
);
  tked_pkg::cfg_t     cfg;
  tked_pkg::key_req_t req;
  logic dec_busy, held_busy, pop, pop_done, pop_hit, pending, out_full;
  logic [8:0] pop_data;
  logic acc;

  assign in_ch.ready = !dec_busy && !held_busy && !pending && !out_full;
  assign acc = in_ch.valid && in_ch.ready;
  assign pop = acc && in_ch.func;
  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= {8'd173, 8'd175, 8'd172, 8'd174, 8'd27, 8'd13, 8'd157, 8'd187};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tked_pkg::REG_UP:    cfg.up <= cfg_ch.data;
        tked_pkg::REG_DOWN:  cfg.down <= cfg_ch.data;
        tked_pkg::REG_LEFT:  cfg.left <= cfg_ch.data;
        tked_pkg::REG_RIGHT: cfg.right <= cfg_ch.data;
        tked_pkg::REG_ESC:   cfg.esc <= cfg_ch.data;
        tked_pkg::REG_ENTER: cfg.enter <= cfg_ch.data;
        tked_pkg::REG_CTRL:  cfg.ctrl <= cfg_ch.data;
        tked_pkg::REG_FKEY:  cfg.fkey <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  tked_decode #(.READ_BYTES(READ_BYTES)) u_dec (
    .clk, .rst, .cfg, .wr(acc && !in_ch.func), .wr_byte(in_ch.in_byte),
    .wr_last(in_ch.last_of_read), .busy(dec_busy), .req, .held_busy
  );

  tked_held #(.HELD_SLOTS(HELD_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_held (
    .clk, .rst, .req, .busy(held_busy), .pop, .pop_done, .pop_hit, .pop_data
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (pop) pending <= 1'b1;
      if (pop_done) begin
        pending <= 1'b0;
        out_full <= 1'b1;
        out_ch.event_valid <= pop_hit;
        out_ch.key_code <= pop_hit ? pop_data[7:0] : 8'd0;
        out_ch.key_pressed <= pop_hit & pop_data[8];
      end else if (out_ch.ready) out_full <= 1'b0;
    end
  end
  assign out_ch.valid = out_full;

`ifndef NO_ASSERTIONS
  a_no_acc_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !acc) else $error("item accepted while result waits");
  a_done_pend: assert property (@(posedge clk) disable iff (rst)
    pop_done |-> pending) else $error("pop result without request");
  a_pend_held: assert property (@(posedge clk) disable iff (rst)
    pop |=> pending) else $error("pop not tracked");
`endif
endmodule

### src/tked_held.sv
// Held-key table plus event ring. One request is handled at a time: slot
// scan (one slot per cycle), then a push into the ring memory when the table changes.
module tked_held #(
  parameter int HELD_SLOTS = tked_pkg::HELD_SLOTS_DEF,
  parameter int QUEUE_DEPTH = tked_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tked_pkg::key_req_t req,
  output logic               busy,
  input  logic               pop,
  output logic               pop_done,
  output logic               pop_hit,
  output logic [8:0]         pop_data
);
  localparam int SW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_PUSH = 3'd2, S_POPRD = 3'd3;

  logic [2:0]    state;
  logic [7:0]    slots [HELD_SLOTS];
  logic [SW:0]   idx;
  logic [SW:0]   free_idx;
  logic          free_found;
  logic          press;
  logic [7:0]    key;
  logic [8:0]    ring [QUEUE_DEPTH];
  logic [QW-1:0] rd_ptr, wr_ptr;
  logic [QW-1:0] wr_ptr_next, rd_ptr_next;
  logic [SW-1:0] cur;

  assign busy = (state != S_IDLE) || req.valid;
  assign cur = idx[SW-1:0];
  assign wr_ptr_next = (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_PUSH && wr_ptr_next != rd_ptr) ring[wr_ptr] <= {press, key};
    pop_data <= ring[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_ptr <= '0;
      wr_ptr <= '0;
      pop_done <= 1'b0;
      pop_hit <= 1'b0;
      for (int s = 0; s < HELD_SLOTS; s++) slots[s] <= 8'd0;
    end else begin
      pop_done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_SCAN;
            idx <= '0;
            free_found <= 1'b0;
            press <= req.press;
            key <= req.key;
          end else if (pop) begin
            state <= S_POPRD;
          end
        end
        S_SCAN: begin
          if (idx == (SW+1)'(HELD_SLOTS)) begin
            // press with free slot goes in; otherwise nothing
            if (press && free_found) begin
              slots[free_idx[SW-1:0]] <= key;
              state <= S_PUSH;
            end else begin
              state <= S_IDLE;
            end
          end else if (slots[cur] == key) begin
            if (press) state <= S_IDLE;
            else begin
              slots[cur] <= 8'd0;
              state <= S_PUSH;
            end
          end else begin
            if (!free_found && slots[cur] == 8'd0) begin
              free_found <= 1'b1;
              free_idx <= idx;
            end
            idx <= idx + 1'b1;
          end
        end
        S_PUSH: begin
          if (wr_ptr_next != rd_ptr) wr_ptr <= wr_ptr_next;
          state <= S_IDLE;
        end
        S_POPRD: begin
          pop_done <= 1'b1;
          pop_hit <= rd_ptr != wr_ptr;
          if (rd_ptr != wr_ptr) rd_ptr <= rd_ptr_next;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop_done |-> $past(state) == S_POPRD) else $error("pop_done out of sequence");
  a_wr_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |=> $stable(wr_ptr)) else $error("ring write during scan");
  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |=> $stable(rd_ptr)) else $error("read pointer moved on push");
`endif
endmodule

### src/tked_decode.sv
// Read buffer and parse sequencer: walks the stored bytes one at a time,
// issuing key requests to the held-key table and waiting while it is busy.
module tked_decode #(
  parameter int READ_BYTES = tked_pkg::READ_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  tked_pkg::cfg_t     cfg,
  input  logic               wr,
  input  logic [7:0]         wr_byte,
  input  logic               wr_last,
  output logic               busy,
  output tked_pkg::key_req_t req,
  input  logic               held_busy
);
  localparam int CW = $clog2(READ_BYTES + 1);
  localparam int AW = $clog2(READ_BYTES);
  localparam logic [3:0] D_IDLE = 4'd0, D_FETCH = 4'd1, D_LOOK = 4'd2, D_B1 = 4'd3,
    D_B2 = 4'd4, D_NUM = 4'd5, D_EMIT = 4'd6, D_WAIT = 4'd7, D_SENT = 4'd8;

  logic [7:0]    buffer [READ_BYTES];
  logic [CW-1:0] count, n, pos, j;
  logic [3:0]    state;
  logic [7:0]    rdata, b0, b1;
  logic [CW-1:0] rd_addr;
  logic [6:0]    num;
  logic [7:0]    key;
  logic          press;
  logic [CW:0]   pos_lim;
  logic [7:0]    arrow;
  logic          arrow_hit;
  logic [6:0]    num_next;

  assign busy = state != D_IDLE;
  assign pos_lim = {1'b0, pos} + (CW+1)'(2);

  // buffer memory, registered read
  always_ff @(posedge clk) begin
    if (wr && state == D_IDLE && count < CW'(READ_BYTES)) buffer[count[AW-1:0]] <= wr_byte;
    rdata <= buffer[rd_addr[AW-1:0]];
  end

  always_comb begin
    arrow_hit = 1'b1;
    case (rdata)
      8'h41: arrow = cfg.up;
      8'h42: arrow = cfg.down;
      8'h43: arrow = cfg.right;
      8'h44: arrow = cfg.left;
      default: begin
        arrow = 8'd0;
        arrow_hit = 1'b0;
      end
    endcase
    num_next = (num > 7'd9) ? 7'd99 : 7'(num * 7'd10 + 7'(rdata - 8'h30));
    if (num_next > 7'd99) num_next = 7'd99;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      count <= '0;
      req <= '0;
    end else begin
      req.valid <= 1'b0;
      case (state)
        D_IDLE: begin
          if (wr) begin
            if (wr_last) begin
              n <= (count < CW'(READ_BYTES)) ? count + 1'b1 : count;
              count <= '0;
              pos <= '0;
              state <= D_FETCH;
            end else if (count < CW'(READ_BYTES)) begin
              count <= count + 1'b1;
            end
          end
        end
        D_FETCH: begin
          if (pos >= n) state <= D_IDLE;
          else begin
            rd_addr <= pos;
            state <= D_LOOK;
          end
        end
        D_LOOK: state <= D_B1;
        D_B1: begin
          b0 <= rdata;
          if (rdata == tked_pkg::BYTE_NUL) begin
            if ({1'b0, pos} + (CW+1)'(1) < {1'b0, n}) begin
              rd_addr <= pos + 1'b1;
              state <= D_SENT;
            end else begin
              pos <= pos + 1'b1;
              state <= D_FETCH;
            end
          end else if (rdata == tked_pkg::BYTE_ESC) begin
            if (pos_lim < {1'b0, n}) begin
              rd_addr <= pos + 1'b1;
              state <= D_B2;
            end else begin
              key <= cfg.esc; press <= 1'b1; pos <= pos + 1'b1; state <= D_EMIT;
            end
          end else if (rdata == tked_pkg::BYTE_CR || rdata == tked_pkg::BYTE_LF) begin
            key <= cfg.enter; press <= 1'b1; pos <= pos + 1'b1; state <= D_EMIT;
          end else begin
            key <= tked_pkg::plain_key(rdata, cfg.ctrl);
            press <= 1'b1; pos <= pos + 1'b1; state <= D_EMIT;
          end
          num <= '0;
        end
        D_SENT: begin
          // rdata is valid in the cycle after the address; wait via b1 flag
          if (b1 == 8'hFF) begin
            key <= tked_pkg::plain_key(rdata, cfg.ctrl);
            press <= 1'b0; pos <= pos + CW'(2); state <= D_EMIT; b1 <= 8'd0;
          end else b1 <= 8'hFF;
        end
        D_B2: begin
          if (b1 == 8'hFF) begin
            b1 <= 8'd0;
            if (rdata == 8'h5B || rdata == 8'h4F) begin
              b0 <= rdata;
              rd_addr <= pos + CW'(2);
              j <= pos + CW'(2);
              state <= D_NUM;
            end else begin
              key <= cfg.esc; press <= 1'b1; pos <= pos + 1'b1; state <= D_EMIT;
            end
          end else b1 <= 8'hFF;
        end
        D_NUM: begin
          if (b1 != 8'hFF) b1 <= 8'hFF;
          else if (b0 == 8'h4F) begin
            b1 <= 8'd0; press <= 1'b1; state <= D_EMIT;
            if (arrow_hit) begin key <= arrow; pos <= pos + CW'(3); end
            else if (rdata >= 8'h50 && rdata <= 8'h53) begin
              key <= cfg.fkey + (rdata - 8'h50); pos <= pos + CW'(3);
            end else begin key <= cfg.esc; pos <= pos + 1'b1; end
          end else if (j == pos + CW'(2) && arrow_hit) begin
            b1 <= 8'd0; press <= 1'b1; key <= arrow; pos <= pos + CW'(3); state <= D_EMIT;
          end else if (rdata >= 8'h30 && rdata <= 8'h39) begin
            num <= num_next;
            b1 <= 8'd0;
            if (j + 1'b1 < n) begin
              j <= j + 1'b1; rd_addr <= j + 1'b1;
            end else begin
              pos <= pos + 1'b1; state <= D_FETCH;
            end
          end else begin
            b1 <= 8'd0;
            if (rdata == 8'h7E) begin
              press <= 1'b1; pos <= j + 1'b1; state <= D_EMIT;
              if (num >= 7'd11 && num <= 7'd15) key <= cfg.fkey + 8'(num - 7'd11);
              else if (num >= 7'd17 && num <= 7'd21) key <= cfg.fkey + 8'(num - 7'd12);
              else key <= 8'd0;
            end else begin
              pos <= pos + 1'b1; state <= D_FETCH;
            end
          end
        end
        D_EMIT: begin
          if (key != 8'd0) begin
            req.valid <= 1'b1; req.press <= press; req.key <= key;
            state <= D_WAIT;
          end else state <= D_FETCH;
        end
        D_WAIT: if (!held_busy) state <= D_FETCH;
        default: state <= D_IDLE;
      endcase
      if (state == D_IDLE) b1 <= 8'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_req_key: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> req.key != 8'd0) else $error("zero key requested");
  a_req_wait: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> state == D_WAIT) else $error("request outside wait");
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(READ_BYTES)) else $error("read count overflow");
`endif
endmodule
